>>> rtl/core/idel_pkg.sv
// Package for the indexed double-ended list: field widths, operation and
// status codes, and the control bundle broadcast to the cell row.
// No dependencies.
package idel_pkg;

    localparam int WORD_W       = 32;
    localparam int MODE_W       = 3;
    localparam int POS_W        = 7;
    localparam int CNT_W        = 7;
    localparam int ST_W         = 2;
    localparam int CAPACITY_DEF = 64;
    localparam int GROUP_N      = 8;   // cells per first-level tap group

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT     = 3'd0,
        MODE_REMOVE     = 3'd1,
        MODE_PUSH_FRONT = 3'd2,
        MODE_PUSH_BACK  = 3'd3,
        MODE_POP_FRONT  = 3'd4,
        MODE_POP_BACK   = 3'd5
    } t_mode;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    // Broadcast to every cell; already qualified by an accepted transaction.
    typedef struct packed {
        logic              ins;   // open a slot at the position, shift up
        logic              rem;   // close the slot at the position, shift down
        logic              tap;   // cell at the position drives its word out
        logic [WORD_W-1:0] word;
    } t_cell_ctl;

endpackage

>>> rtl/core/idel_channels.sv
// Channel interfaces of the indexed double-ended list (valid/ready).
// Depends on idel_pkg.
interface idel_in_if import idel_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] word_in;

    modport source (output valid, mode, position, word_in, input ready);
    modport sink   (input valid, mode, position, word_in, output ready);
endinterface

interface idel_out_if import idel_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] word_out;
    logic [ST_W-1:0]   status;
    logic [CNT_W-1:0]  count;

    modport source (output valid, word_out, status, count, input ready);
    modport sink   (input valid, word_out, status, count, output ready);
endinterface

>>> rtl/core/idel_cell.sv
// One list slot: holds a word, takes a neighbor's word when the row shifts.
// Depends on idel_pkg.
module idel_cell import idel_pkg::*; #(
    parameter int PW  = POS_W,
    parameter int IDX = 0
) (
    input  logic              i_clk,
    input  t_cell_ctl         i_ctl,
    input  logic [PW-1:0]     i_pos,
    input  logic [WORD_W-1:0] i_prev,   // word of slot IDX-1
    input  logic [WORD_W-1:0] i_next,   // word of slot IDX+1
    output logic [WORD_W-1:0] o_data,
    output logic [WORD_W-1:0] o_tap
);

    localparam logic [PW-1:0] IDX_V = PW'(IDX);

    logic [WORD_W-1:0] r_data;
    logic [WORD_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.ins) begin
            if (IDX_V == i_pos) begin
                n_data = i_ctl.word;
            end else if (IDX_V > i_pos) begin
                n_data = i_prev;
            end
        end else if (i_ctl.rem) begin
            if (IDX_V >= i_pos) begin
                n_data = i_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_tap  = (i_ctl.tap && (IDX_V == i_pos)) ? r_data : '0;

endmodule

>>> rtl/core/idel_tap_group.sv
// First level of the read tree: registered OR of a group of cell taps.
// Depends on idel_pkg.
module idel_tap_group import idel_pkg::*; #(
    parameter int N = GROUP_N
) (
    input  logic                      i_clk,
    input  logic [N-1:0][WORD_W-1:0]  i_tap,
    output logic [WORD_W-1:0]         o_word
);

    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] n_word;

    always_comb begin
        n_word = '0;
        for (int k = 0; k < N; k++) begin
            n_word = n_word | i_tap[k];
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

>>> rtl/core/indexed_double_ended_list.sv
// Indexed double-ended list: an ordered list of up to CAPACITY 32-bit words.
// Each input transaction is one operation (insert at position, remove at
// position, push front/back, pop front/back) and yields exactly one output
// transaction with the popped word (zero unless a pop succeeded), a status
// (ok, position out of range, full, empty) and the length after the operation.
// Failed operations leave the list untouched. Storage is a row of CAPACITY
// cells; on an insert the cell at the position takes the new word and each
// cell beyond it its lower neighbor's, on a remove each cell at or beyond the
// position its upper neighbor's, all in the same clock, so the list itself
// updates in the accept cycle. The popped word is gathered by a two-level tap
// tree (groups of eight cells, registered, then a final OR into the output
// register). Input is taken when idle or in the cycle the pending result is
// taken, so no new operation enters before the last one's result has left.
// No clearing pass after reset: only slots below the length are ever read.
module indexed_double_ended_list import idel_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    idel_in_if.sink      i_in,
    idel_out_if.source   o_out
);

    localparam int LW = $clog2(CAPACITY + 1);          // length width
    localparam int PW = (LW > POS_W) ? LW : POS_W;     // compare width
    localparam int NG = (CAPACITY + GROUP_N - 1) / GROUP_N;
    localparam logic [LW-1:0] LEN_CAP = LW'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SUM  = 3'b010,   // final OR of the group taps
        S_OUT  = 3'b100    // result offered
    } t_state;

    t_state               r_state, n_state;
    logic [LW-1:0]        r_len, n_len;
    t_status              r_status;
    logic [CNT_W-1:0]     r_count;
    logic                 r_pop;
    logic [WORD_W-1:0]    r_word_out;

    logic                 w_acc;
    logic [PW-1:0]        w_pos_in, w_len_e, w_pos;
    logic                 w_ins, w_rem, w_pop;
    t_status              w_st;
    t_cell_ctl            w_ctl;
    logic [WORD_W-1:0]    w_sum;

    logic [CAPACITY-1:0][WORD_W-1:0] w_data;
    logic [CAPACITY-1:0][WORD_W-1:0] w_tap;
    logic [NG-1:0][WORD_W-1:0]       w_grp;

    // Handshake: take input when idle or while the pending result leaves.
    assign i_in.ready = (r_state == S_IDLE) || ((r_state == S_OUT) && o_out.ready);
    assign w_acc      = i_in.valid && i_in.ready;

    assign w_pos_in = PW'(i_in.position);
    assign w_len_e  = PW'(r_len);

    // Decode and range checks. Insert checks range before full.
    always_comb begin
        w_st  = ST_OK;
        w_ins = 1'b0;
        w_rem = 1'b0;
        w_pop = 1'b0;
        w_pos = '0;
        case (t_mode'(i_in.mode))
            MODE_INSERT: begin
                w_pos = w_pos_in;
                if (w_pos_in > w_len_e) begin
                    w_st = ST_RANGE;
                end else if (r_len == LEN_CAP) begin
                    w_st = ST_FULL;
                end else begin
                    w_ins = 1'b1;
                end
            end
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                w_pos = (t_mode'(i_in.mode) == MODE_PUSH_BACK) ? w_len_e : '0;
                if (r_len == LEN_CAP) begin
                    w_st = ST_FULL;
                end else begin
                    w_ins = 1'b1;
                end
            end
            MODE_REMOVE: begin
                w_pos = w_pos_in;
                if (r_len == '0) begin
                    w_st = ST_EMPTY;
                end else if (w_pos_in >= w_len_e) begin
                    w_st = ST_RANGE;
                end else begin
                    w_rem = 1'b1;
                end
            end
            MODE_POP_FRONT, MODE_POP_BACK: begin
                w_pos = (t_mode'(i_in.mode) == MODE_POP_BACK) ? (w_len_e - PW'(1)) : '0;
                if (r_len == '0) begin
                    w_st = ST_EMPTY;
                end else begin
                    w_rem = 1'b1;
                    w_pop = 1'b1;
                end
            end
            default: begin
                w_st = ST_OK;   // unused modes: no-op
            end
        endcase
    end

    always_comb begin
        n_len = r_len;
        if (w_acc && w_ins) begin
            n_len = r_len + LW'(1);
        end else if (w_acc && w_rem) begin
            n_len = r_len - LW'(1);
        end
    end

    assign w_ctl.ins  = w_acc && w_ins;
    assign w_ctl.rem  = w_acc && w_rem;
    assign w_ctl.tap  = w_acc && w_pop;
    assign w_ctl.word = i_in.word_in;

    // Cell row: each cell sees both neighbors; ends are tied off.
    for (genvar c = 0; c < CAPACITY; c++) begin : g_cell
        logic [WORD_W-1:0] w_prev, w_next;
        if (c == 0) begin : g_first
            assign w_prev = '0;
        end else begin : g_mid_lo
            assign w_prev = w_data[c-1];
        end
        if (c == CAPACITY - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_mid_hi
            assign w_next = w_data[c+1];
        end
        idel_cell #(
            .PW  (PW),
            .IDX (c)
        ) u_cell (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_pos  (w_pos),
            .i_prev (w_prev),
            .i_next (w_next),
            .o_data (w_data[c]),
            .o_tap  (w_tap[c])
        );
    end

    // First tree level: one registered OR per group of cells.
    for (genvar g = 0; g < NG; g++) begin : g_grp
        localparam int LO = g * GROUP_N;
        localparam int N  = ((CAPACITY - LO) < GROUP_N) ? (CAPACITY - LO) : GROUP_N;
        idel_tap_group #(
            .N (N)
        ) u_grp (
            .i_clk  (i_clk),
            .i_tap  (w_tap[LO +: N]),
            .o_word (w_grp[g])
        );
    end

    // Second tree level.
    always_comb begin
        w_sum = '0;
        for (int g = 0; g < NG; g++) begin
            w_sum = w_sum | w_grp[g];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_acc) n_state = S_SUM;
            S_SUM:   n_state = S_OUT;
            S_OUT: begin
                if (o_out.ready) begin
                    n_state = w_acc ? S_SUM : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_status <= w_st;
            r_count  <= CNT_W'(n_len);
            r_pop    <= w_pop;
        end
        if (r_state == S_SUM) begin
            r_word_out <= r_pop ? w_sum : '0;
        end
    end

    assign o_out.valid    = (r_state == S_OUT);
    assign o_out.word_out = r_word_out;
    assign o_out.status   = r_status;
    assign o_out.count    = r_count;

endmodule
